FILE: hw/rtl/brf_pkg.sv
// shared types, codes and helpers for the banked register file
package brf_pkg;

    localparam int NUM_BANKS = 6;
    localparam int SLOTS = 7;

    localparam logic [3:0] ACT_RD      = 4'd0;
    localparam logic [3:0] ACT_WR      = 4'd1;
    localparam logic [3:0] ACT_RD_MODE = 4'd2;
    localparam logic [3:0] ACT_WR_MODE = 4'd3;
    localparam logic [3:0] ACT_RD_CPSR = 4'd4;
    localparam logic [3:0] ACT_WR_CPSR = 4'd5;
    localparam logic [3:0] ACT_RD_SPSR = 4'd6;
    localparam logic [3:0] ACT_WR_SPSR = 4'd7;
    localparam logic [3:0] ACT_SWITCH  = 4'd8;
    localparam logic [3:0] ACT_IRQ     = 4'd9;
    localparam logic [3:0] ACT_UND     = 4'd10;
    localparam logic [3:0] ACT_COND    = 4'd11;
    localparam logic [3:0] ACT_HALT    = 4'd12;

    localparam logic [2:0] BANK_USR = 3'd0;
    localparam logic [2:0] BANK_FIQ = 3'd1;
    localparam logic [2:0] BANK_IRQ = 3'd2;
    localparam logic [2:0] BANK_SVC = 3'd3;
    localparam logic [2:0] BANK_ABT = 3'd4;
    localparam logic [2:0] BANK_UND = 3'd5;

    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1b;

    localparam logic [31:0] CPSR_RESET = 32'h0000_00d3;
    localparam int BIT_T = 5;
    localparam int BIT_I = 7;

    localparam logic [31:0] VEC_IRQ = 32'h0000_0018;
    localparam logic [31:0] VEC_UND = 32'h0000_0004;
    localparam logic [2:0] BRANCH_MASK = 3'b111;
    localparam logic [2:0] BRANCH_FORM = 3'b101;

    localparam logic [3:0] REG_LR = 4'd14;
    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_PC = 4'd15;
    localparam logic [3:0] REG_HI_FIRST = 4'd8;
    localparam logic [3:0] REG_HI_LAST = 4'd12;

    localparam logic [0:0] CFG_EXC_BASE = 1'b0;
    localparam logic [0:0] CFG_ARCH_V5  = 1'b1;

    localparam logic [3:0] COND_EQ = 4'd0;
    localparam logic [3:0] COND_NE = 4'd1;
    localparam logic [3:0] COND_CS = 4'd2;
    localparam logic [3:0] COND_CC = 4'd3;
    localparam logic [3:0] COND_MI = 4'd4;
    localparam logic [3:0] COND_PL = 4'd5;
    localparam logic [3:0] COND_VS = 4'd6;
    localparam logic [3:0] COND_VC = 4'd7;
    localparam logic [3:0] COND_HI = 4'd8;
    localparam logic [3:0] COND_LS = 4'd9;
    localparam logic [3:0] COND_GE = 4'd10;
    localparam logic [3:0] COND_LT = 4'd11;
    localparam logic [3:0] COND_GT = 4'd12;
    localparam logic [3:0] COND_LE = 4'd13;
    localparam logic [3:0] COND_AL = 4'd14;

    localparam int IN_DATA_W = 80;
    localparam int OUT_DATA_W = 72;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [31:0] write_value;
        logic [4:0]  mode_code;
        logic [3:0]  reg_index;
        logic [3:0]  action;
    } brf_req_t;

    typedef struct packed {
        logic        halt_state;
        logic [4:0]  current_mode;
        logic [31:0] redirect_addr;
        logic        redirect;
        logic        cond_pass;
        logic [31:0] read_data;
    } brf_res_t;

    function automatic logic [2:0] bank_of(input logic [4:0] mode);
        logic [2:0] b;
        unique case (mode)
            MODE_FIQ: b = BANK_FIQ;
            MODE_IRQ: b = BANK_IRQ;
            MODE_SVC: b = BANK_SVC;
            MODE_ABT: b = BANK_ABT;
            MODE_UND: b = BANK_UND;
            default:  b = BANK_USR;
        endcase
        return b;
    endfunction

    function automatic logic [2:0] low_slot(input logic [2:0] bank);
        return (bank == BANK_FIQ) ? BANK_FIQ : BANK_USR;
    endfunction

endpackage

FILE: hw/rtl/banked_register_file_mode_control.sv
// top level: request register, core and result register with stream handshakes
//
// banked register file and mode control
// requests enter on the s_axis channel, one per tdata beat, and each gives
// exactly one result on the m_axis channel, in order.
// cfg channel: cfg_index 0 writes the exception vector base, 1 writes the
// architecture select (bit 0 of cfg_data); cfg_ready is always high. The user
// must write only while no request is in flight; the block does not enforce it.
// a request is captured in the request register, executed by the core into the
// result register and offered on m_axis from there.
// throughput: one request per cycle while m_axis takes results; every access,
// mode switch and exception entry, bank copies included, completes in one
// combinational pass of the core between the request and result registers.
// a stalled m_axis holds the result register; one more request waits in the
// request register, then s_axis_tready drops until the result is taken.
// reset: all general, banked and saved status registers clear to zero, the
// current status becomes 0xd3 (supervisor, interrupts masked), halt clears,
// both config registers clear; no clearing pass is needed.
module banked_register_file_mode_control
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // action, reg_index, mode_code, write_value, instr_word, zero fill
    input  logic [brf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_data, cond_pass, redirect, redirect_addr, current_mode, halt_state
    output logic [brf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [0:0]                     cfg_index,
    input  logic [31:0]                    cfg_data
);
    import brf_pkg::*;

    brf_req_t in_req_reg;
    logic     in_valid_reg;
    brf_res_t out_res_reg;
    logic     out_valid_reg;
    brf_res_t res;
    logic     exec_fire;
    logic     in_fire;

    assign exec_fire = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || exec_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    brf_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (exec_fire),
        .req       (in_req_reg),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (exec_fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_req_reg <= s_axis_tdata[$bits(brf_req_t)-1:0];
        end
        if (exec_fire)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_res_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !exec_fire |-> out_valid_reg && !m_axis_tready)
        else $error("request held while result path free");

    a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> out_valid_reg)
        else $error("executed request produced no result");

endmodule

FILE: hw/rtl/brf_cond.sv
// condition code evaluation against the status flags
module brf_cond
(
    input  logic [3:0]  flags,
    input  logic [31:0] instr_word,
    input  logic        arch_v5,
    output logic        pass
);
    import brf_pkg::*;

    logic n;
    logic z;
    logic c;
    logic v;

    assign n = flags[3];
    assign z = flags[2];
    assign c = flags[1];
    assign v = flags[0];

    always_comb
    begin
        unique case (instr_word[31:28])
            COND_EQ: pass = z;
            COND_NE: pass = !z;
            COND_CS: pass = c;
            COND_CC: pass = !c;
            COND_MI: pass = n;
            COND_PL: pass = !n;
            COND_VS: pass = v;
            COND_VC: pass = !v;
            COND_HI: pass = c && !z;
            COND_LS: pass = !c || z;
            COND_GE: pass = (n == v);
            COND_LT: pass = (n != v);
            COND_GT: pass = !z && (n == v);
            COND_LE: pass = z || (n != v);
            COND_AL: pass = 1'b1;
            default: pass = arch_v5 && ((instr_word[27:25] & BRANCH_MASK) == BRANCH_FORM);
        endcase
    end

endmodule

FILE: hw/rtl/brf_core.sv
// register state, banking, status and exception entry for one request per cycle while fire is high
module brf_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  brf_pkg::brf_req_t req,
    input  logic              cfg_valid,
    input  logic [0:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output brf_pkg::brf_res_t res
);
    import brf_pkg::*;

    logic [31:0] vis_reg  [16];
    logic [31:0] vis_next [16];
    logic [31:0] bnk_reg  [NUM_BANKS][SLOTS];
    logic [31:0] bnk_next [NUM_BANKS][SLOTS];
    logic [31:0] sps_reg  [NUM_BANKS];
    logic [31:0] sps_next [NUM_BANKS];
    logic [31:0] cpsr_reg;
    logic [31:0] cpsr_next;
    logic        halt_reg;
    logic        halt_next;
    logic [31:0] exc_base_reg;
    logic        arch_v5_reg;

    logic [2:0]  cur_bank;
    logic [2:0]  acc_bank;
    logic [2:0]  dst_bank;
    logic [4:0]  sw_mode;
    logic [2:0]  slot;
    logic        is_hi;
    logic        is_lo;
    logic        fiq_x_acc;
    logic        fiq_x_sw;
    logic        is_exc;
    logic        thumb;
    logic [31:0] pc_align;
    logic [31:0] pc_new;
    logic [31:0] exc_sum;
    logic [31:0] exc_addr;
    logic [31:0] link;
    logic [31:0] loc_val;
    logic        cond_ok;

    brf_cond u_cond
    (
        .flags      (cpsr_reg[31:28]),
        .instr_word (req.instr_word),
        .arch_v5    (arch_v5_reg),
        .pass       (cond_ok)
    );

    assign cur_bank = bank_of(cpsr_reg[4:0]);
    assign acc_bank = bank_of(req.mode_code);
    assign is_exc = (req.action == ACT_IRQ) || (req.action == ACT_UND);
    assign sw_mode = (req.action == ACT_IRQ) ? MODE_IRQ :
                     (req.action == ACT_UND) ? MODE_UND : req.mode_code;
    assign dst_bank = bank_of(sw_mode);
    assign slot = req.reg_index[2:0];
    assign is_hi = (req.reg_index == REG_SP) || (req.reg_index == REG_LR);
    assign is_lo = (req.reg_index >= REG_HI_FIRST) && (req.reg_index <= REG_HI_LAST);
    assign fiq_x_acc = (acc_bank == BANK_FIQ) != (cur_bank == BANK_FIQ);
    assign fiq_x_sw = (cur_bank == BANK_FIQ) != (dst_bank == BANK_FIQ);

    // program counter write in the current state
    assign thumb = cpsr_reg[BIT_T];
    assign pc_align = thumb ? {req.write_value[31:1], 1'b0} : {req.write_value[31:2], 2'b00};
    assign pc_new = pc_align + (thumb ? 32'd4 : 32'd8);

    // exception entry always lands in arm state
    assign exc_sum = exc_base_reg + ((req.action == ACT_IRQ) ? VEC_IRQ : VEC_UND);
    assign exc_addr = {exc_sum[31:2], 2'b00};
    assign link = ((req.action == ACT_IRQ) && thumb) ? vis_reg[15] : vis_reg[15] - 32'd4;

    always_comb
    begin
        if (is_hi && (acc_bank != cur_bank))
        begin
            loc_val = bnk_reg[acc_bank][slot];
        end
        else if (is_lo && fiq_x_acc)
        begin
            loc_val = bnk_reg[low_slot(acc_bank)][slot];
        end
        else
        begin
            loc_val = vis_reg[req.reg_index];
        end
    end

    always_comb
    begin
        vis_next = vis_reg;
        bnk_next = bnk_reg;
        sps_next = sps_reg;
        cpsr_next = cpsr_reg;
        halt_next = halt_reg;
        res = '0;
        if (fire)
        begin
            unique case (req.action)
                ACT_RD:
                begin
                    res.read_data = vis_reg[req.reg_index];
                end
                ACT_WR:
                begin
                    if (req.reg_index == REG_PC)
                    begin
                        vis_next[15] = pc_new;
                        res.redirect = 1'b1;
                        res.redirect_addr = pc_align;
                    end
                    else
                    begin
                        vis_next[req.reg_index] = req.write_value;
                    end
                end
                ACT_RD_MODE:
                begin
                    res.read_data = loc_val;
                end
                ACT_WR_MODE:
                begin
                    if (req.reg_index == REG_PC)
                    begin
                        vis_next[15] = pc_new;
                        res.redirect = 1'b1;
                        res.redirect_addr = pc_align;
                    end
                    else if (is_hi && (acc_bank != cur_bank))
                    begin
                        bnk_next[acc_bank][slot] = req.write_value;
                    end
                    else if (is_lo && fiq_x_acc)
                    begin
                        bnk_next[low_slot(acc_bank)][slot] = req.write_value;
                    end
                    else
                    begin
                        vis_next[req.reg_index] = req.write_value;
                    end
                end
                ACT_RD_CPSR:
                begin
                    res.read_data = cpsr_reg;
                end
                ACT_WR_CPSR:
                begin
                    cpsr_next = req.write_value;
                end
                ACT_RD_SPSR:
                begin
                    res.read_data = sps_reg[acc_bank];
                end
                ACT_WR_SPSR:
                begin
                    sps_next[acc_bank] = req.write_value;
                end
                ACT_SWITCH, ACT_IRQ, ACT_UND:
                begin
                    if (is_exc)
                    begin
                        sps_next[dst_bank] = cpsr_reg;
                    end
                    cpsr_next[4:0] = sw_mode;
                    if (cur_bank != dst_bank)
                    begin
                        bnk_next[cur_bank][5] = vis_reg[13];
                        bnk_next[cur_bank][6] = vis_reg[14];
                        vis_next[13] = bnk_reg[dst_bank][5];
                        vis_next[14] = bnk_reg[dst_bank][6];
                        if (fiq_x_sw)
                        begin
                            for (int i = 0; i < 5; i++)
                            begin
                                bnk_next[low_slot(cur_bank)][i] = vis_reg[8 + i];
                                vis_next[8 + i] = bnk_reg[low_slot(dst_bank)][i];
                            end
                        end
                    end
                    if (is_exc)
                    begin
                        cpsr_next[BIT_I] = 1'b1;
                        cpsr_next[BIT_T] = 1'b0;
                        vis_next[14] = link;
                        vis_next[15] = exc_addr + 32'd8;
                        res.redirect = 1'b1;
                        res.redirect_addr = exc_addr;
                    end
                    if (req.action == ACT_IRQ)
                    begin
                        halt_next = 1'b0;
                    end
                end
                ACT_COND:
                begin
                    res.cond_pass = cond_ok;
                end
                ACT_HALT:
                begin
                    halt_next = req.write_value[0];
                end
                default:
                begin
                end
            endcase
        end
        res.current_mode = cpsr_next[4:0];
        res.halt_state = halt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                vis_reg[i] <= '0;
            end
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                sps_reg[b] <= '0;
                for (int s = 0; s < SLOTS; s++)
                begin
                    bnk_reg[b][s] <= '0;
                end
            end
            cpsr_reg <= CPSR_RESET;
            halt_reg <= 1'b0;
            exc_base_reg <= '0;
            arch_v5_reg <= 1'b0;
        end
        else
        begin
            vis_reg <= vis_next;
            bnk_reg <= bnk_next;
            sps_reg <= sps_next;
            cpsr_reg <= cpsr_next;
            halt_reg <= halt_next;
            if (cfg_valid && (cfg_index == CFG_EXC_BASE))
            begin
                exc_base_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == CFG_ARCH_V5))
            begin
                arch_v5_reg <= cfg_data[0];
            end
        end
    end

    a_redirect_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.redirect |-> !res.redirect_addr[0])
        else $error("redirect address not halfword aligned");

    a_irq_entry: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.action == ACT_IRQ) |=>
            (cpsr_reg[4:0] == MODE_IRQ) && cpsr_reg[BIT_I] && !cpsr_reg[BIT_T] && !halt_reg)
        else $error("irq entry left wrong status");

    a_und_entry: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.action == ACT_UND) |=>
            (cpsr_reg[4:0] == MODE_UND) && cpsr_reg[BIT_I] && !cpsr_reg[BIT_T])
        else $error("undefined entry left wrong status");

    a_saved_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.action == ACT_IRQ) |=> sps_reg[BANK_IRQ] == $past(cpsr_reg))
        else $error("irq entry did not save status");

endmodule

FILE: tb/sv/brf_checker.sv
// request/result checker with its own model of the banked register file
`timescale 1ns / 100ps

module brf_checker
    import brf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output int                    fail_count,
    output int                    pending_count
);

    localparam int SP_SLOT = REG_SP - REG_HI_FIRST;
    localparam int LR_SLOT = REG_LR - REG_HI_FIRST;

    logic [31:0] gpr [16];
    logic [31:0] bank_copy [NUM_BANKS][SLOTS];
    logic [31:0] spsr [NUM_BANKS];
    logic [31:0] cpsr;
    logic        halted;
    logic [31:0] vec_base;
    logic        v5_sel;

    brf_res_t    exec_results [$];

    function automatic void clear_state();
        for (int i = 0; i < 16; i++)
            gpr[i] = '0;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            spsr[b] = '0;
            for (int s = 0; s < SLOTS; s++)
                bank_copy[b][s] = '0;
        end
        cpsr = CPSR_RESET;
        halted = 1'b0;
        vec_base = '0;
        v5_sel = 1'b0;
        exec_results.delete();
    endfunction

    function automatic logic [2:0] mode_bank(input logic [4:0] m);
        case (m)
            MODE_FIQ: return BANK_FIQ;
            MODE_IRQ: return BANK_IRQ;
            MODE_SVC: return BANK_SVC;
            MODE_ABT: return BANK_ABT;
            MODE_UND: return BANK_UND;
            default:  return BANK_USR;
        endcase
    endfunction

    // which copy of r8..r12 a bank sees
    function automatic logic [2:0] hi_copy(input logic [2:0] b);
        return (b == BANK_FIQ) ? BANK_FIQ : BANK_USR;
    endfunction

    function automatic void swap_mode(input logic [4:0] m);
        logic [2:0] ob;
        logic [2:0] nb;
        ob = mode_bank(cpsr[4:0]);
        nb = mode_bank(m);
        cpsr[4:0] = m;
        if (ob != nb)
        begin
            bank_copy[ob][SP_SLOT] = gpr[REG_SP];
            bank_copy[ob][LR_SLOT] = gpr[REG_LR];
            gpr[REG_SP] = bank_copy[nb][SP_SLOT];
            gpr[REG_LR] = bank_copy[nb][LR_SLOT];
            if ((ob == BANK_FIQ) != (nb == BANK_FIQ))
            begin
                for (int i = 0; i < 5; i++)
                begin
                    bank_copy[hi_copy(ob)][i] = gpr[REG_HI_FIRST + i];
                    gpr[REG_HI_FIRST + i] = bank_copy[hi_copy(nb)][i];
                end
            end
        end
    endfunction

    // returns 1 when the register seen by mode m lives in a banked copy
    function automatic bit banked_loc(input logic [3:0] r, input logic [4:0] m,
                                      output logic [2:0] b, output int s);
        logic [2:0] want;
        logic [2:0] cur;
        want = mode_bank(m);
        cur = mode_bank(cpsr[4:0]);
        b = BANK_USR;
        s = int'(r) - int'(REG_HI_FIRST);
        if ((r == REG_SP || r == REG_LR) && want != cur)
        begin
            b = want;
            return 1'b1;
        end
        if (r >= REG_HI_FIRST && r <= REG_HI_LAST
            && ((want == BANK_FIQ) != (cur == BANK_FIQ)))
        begin
            b = hi_copy(want);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] pc_write(input logic [31:0] v);
        logic [31:0] a;
        if (cpsr[BIT_T])
        begin
            a = {v[31:1], 1'b0};
            gpr[REG_PC] = a + 32'd4;
        end
        else
        begin
            a = {v[31:2], 2'b00};
            gpr[REG_PC] = a + 32'd8;
        end
        return a;
    endfunction

    function automatic logic [31:0] take_exception(input logic [2:0] b, input logic [4:0] m,
                                                   input logic [31:0] vec, input bit thumb_link);
        logic was_thumb;
        was_thumb = cpsr[BIT_T];
        spsr[b] = cpsr;
        swap_mode(m);
        cpsr[BIT_I] = 1'b1;
        cpsr[BIT_T] = 1'b0;
        gpr[REG_LR] = (thumb_link && was_thumb) ? gpr[REG_PC] : gpr[REG_PC] - 32'd4;
        return pc_write(vec_base + vec);
    endfunction

    function automatic logic cond_met(input logic [31:0] instr);
        logic n;
        logic z;
        logic c;
        logic v;
        {n, z, c, v} = cpsr[31:28];
        case (instr[31:28])
            COND_EQ: return z;
            COND_NE: return !z;
            COND_CS: return c;
            COND_CC: return !c;
            COND_MI: return n;
            COND_PL: return !n;
            COND_VS: return v;
            COND_VC: return !v;
            COND_HI: return c && !z;
            COND_LS: return !c || z;
            COND_GE: return n == v;
            COND_LT: return n != v;
            COND_GT: return !z && n == v;
            COND_LE: return z || n != v;
            COND_AL: return 1'b1;
            default: return v5_sel && ((instr[27:25] & BRANCH_MASK) == BRANCH_FORM);
        endcase
    endfunction

    function automatic brf_res_t execute_request(input brf_req_t req);
        brf_res_t   res;
        logic [2:0] b;
        int         s;
        res = '0;
        case (req.action)
            ACT_RD:
                res.read_data = gpr[req.reg_index];
            ACT_WR:
                if (req.reg_index == REG_PC)
                begin
                    res.redirect = 1'b1;
                    res.redirect_addr = pc_write(req.write_value);
                end
                else
                    gpr[req.reg_index] = req.write_value;
            ACT_RD_MODE:
                if (banked_loc(req.reg_index, req.mode_code, b, s))
                    res.read_data = bank_copy[b][s];
                else
                    res.read_data = gpr[req.reg_index];
            ACT_WR_MODE:
                if (req.reg_index == REG_PC)
                begin
                    res.redirect = 1'b1;
                    res.redirect_addr = pc_write(req.write_value);
                end
                else if (banked_loc(req.reg_index, req.mode_code, b, s))
                    bank_copy[b][s] = req.write_value;
                else
                    gpr[req.reg_index] = req.write_value;
            ACT_RD_CPSR:
                res.read_data = cpsr;
            ACT_WR_CPSR:
                cpsr = req.write_value;
            ACT_RD_SPSR:
                res.read_data = spsr[mode_bank(req.mode_code)];
            ACT_WR_SPSR:
                spsr[mode_bank(req.mode_code)] = req.write_value;
            ACT_SWITCH:
                swap_mode(req.mode_code);
            ACT_IRQ:
            begin
                halted = 1'b0;
                res.redirect = 1'b1;
                res.redirect_addr = take_exception(BANK_IRQ, MODE_IRQ, VEC_IRQ, 1'b1);
            end
            ACT_UND:
            begin
                res.redirect = 1'b1;
                res.redirect_addr = take_exception(BANK_UND, MODE_UND, VEC_UND, 1'b0);
            end
            ACT_COND:
                res.cond_pass = cond_met(req.instr_word);
            ACT_HALT:
                halted = req.write_value[0];
            default:
                ;
        endcase
        res.current_mode = cpsr[4:0];
        res.halt_state = halted;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < 100)
            $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_result(input brf_res_t got);
        brf_res_t want;
        if (exec_results.size() == 0)
        begin
            report_mismatch("result with no request pending", got.read_data, '0);
        end
        else
        begin
            want = exec_results.pop_front();
            if (got.read_data !== want.read_data)
                report_mismatch("read_data", got.read_data, want.read_data);
            if (got.cond_pass !== want.cond_pass)
                report_mismatch("cond_pass", 32'(got.cond_pass), 32'(want.cond_pass));
            if (got.redirect !== want.redirect)
                report_mismatch("redirect", 32'(got.redirect), 32'(want.redirect));
            if (got.redirect_addr !== want.redirect_addr)
                report_mismatch("redirect_addr", got.redirect_addr, want.redirect_addr);
            if (got.current_mode !== want.current_mode)
                report_mismatch("current_mode", 32'(got.current_mode),
                                32'(want.current_mode));
            if (got.halt_state !== want.halt_state)
                report_mismatch("halt_state", 32'(got.halt_state), 32'(want.halt_state));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            pending_count = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(brf_res_t'(m_axis_tdata));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_EXC_BASE)
                    vec_base = cfg_data;
                else
                    v5_sel = cfg_data[0];
            end
            if (s_axis_tvalid && s_axis_tready)
                exec_results.push_back(execute_request(s_axis_tdata[$bits(brf_req_t)-1:0]));
            pending_count = exec_results.size();
        end
    end

endmodule

FILE: tb/sv/banked_register_file_mode_control_tb.sv
// testbench top: clock, reset, request and config stimulus, verdict
`timescale 1ns / 100ps

module banked_register_file_mode_control_tb;
    import brf_pkg::*;

    localparam logic [3:0] ACT_SPARE_LO = 4'd13;
    localparam logic [3:0] ACT_SPARE_HI = 4'd15;
    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_SYS = 5'h1f;
    localparam logic [4:0] MODE_BAD = 5'h00;
    localparam int         PHASES = 4;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [0:0]            cfg_index = CFG_EXC_BASE;
    logic [31:0]           cfg_data = '0;
    int                    fail_count;
    int                    pending_count;
    bit                    calm = 1'b0;

    logic [4:0] known_modes [7] = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
                                    MODE_ABT, MODE_UND, MODE_SYS};

    banked_register_file_mode_control u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    brf_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 37);

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic brf_req_t make_request(input logic [3:0] act, input logic [3:0] r,
                                              input logic [4:0] m, input logic [31:0] val,
                                              input logic [31:0] instr);
        brf_req_t req;
        req.action = act;
        req.reg_index = r;
        req.mode_code = m;
        req.write_value = val;
        req.instr_word = instr;
        return req;
    endfunction

    function automatic brf_req_t random_request();
        brf_req_t req;
        req.action = ($urandom_range(0, 99) < 4) ? 4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI))
                                                 : 4'($urandom_range(ACT_RD, ACT_HALT));
        req.reg_index = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(8, 15))
                                                    : 4'($urandom);
        req.mode_code = ($urandom_range(0, 99) < 80) ? known_modes[$urandom_range(0, 6)]
                                                     : 5'($urandom);
        req.write_value = $urandom;
        req.instr_word = $urandom;
        // status writes mostly keep a real mode so banking stays exercised
        if (req.action == ACT_WR_CPSR && $urandom_range(0, 99) < 75)
            req.write_value[4:0] = known_modes[$urandom_range(0, 6)];
        if (req.action == ACT_COND && $urandom_range(0, 99) < 20)
            req.instr_word[27:25] = BRANCH_FORM;
        return req;
    endfunction

    task automatic send_request(input brf_req_t req);
        while (!calm && $urandom_range(0, 99) < 37)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_W - $bits(brf_req_t)){1'b0}}, req};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic write_config(input logic [31:0] base, input logic v5);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_EXC_BASE;
        cfg_data <= base;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_index <= CFG_ARCH_V5;
        cfg_data <= {31'b0, v5};
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        brf_req_t    directed [$];
        logic [31:0] phase_base [PHASES];
        logic        phase_v5 [PHASES];
        int          phase_items [PHASES];

        phase_base = '{32'hffff_ffff, 32'h0000_0000, $urandom, $urandom};
        phase_v5 = '{1'b1, 1'b0, 1'b1, 1'b0};
        phase_items = '{200, 500, 500, 400};

        directed.push_back(make_request(ACT_RD, REG_PC, MODE_SVC, '0, '0));
        directed.push_back(make_request(ACT_RD_CPSR, 4'd0, MODE_SVC, '0, '0));
        directed.push_back(make_request(ACT_WR, 4'd0, MODE_SVC, 32'hffff_ffff, '0));
        directed.push_back(make_request(ACT_WR, REG_PC, MODE_SVC, 32'h1234_5677, '0));
        directed.push_back(make_request(ACT_RD, REG_PC, MODE_SVC, '0, '0));
        directed.push_back(make_request(ACT_WR_MODE, REG_SP, MODE_IRQ, 32'haaaa_5555, '0));
        directed.push_back(make_request(ACT_RD_MODE, REG_SP, MODE_IRQ, '0, '0));
        directed.push_back(make_request(ACT_SWITCH, 4'd0, MODE_FIQ, '0, '0));
        directed.push_back(make_request(ACT_WR, REG_HI_FIRST, MODE_FIQ, 32'hdead_beef, '0));
        directed.push_back(make_request(ACT_RD_MODE, REG_HI_FIRST, MODE_USR, '0, '0));
        directed.push_back(make_request(ACT_WR_MODE, REG_PC, MODE_USR, 32'h0000_0003, '0));
        directed.push_back(make_request(ACT_WR_SPSR, 4'd0, MODE_BAD, 32'h8000_001f, '0));
        directed.push_back(make_request(ACT_RD_SPSR, 4'd0, MODE_USR, '0, '0));
        directed.push_back(make_request(ACT_SWITCH, 4'd0, MODE_BAD, '0, '0));
        directed.push_back(make_request(ACT_WR_CPSR, 4'd0, MODE_USR, 32'hf000_0030, '0));
        directed.push_back(make_request(ACT_WR, REG_PC, MODE_USR, 32'h0000_0003, '0));
        directed.push_back(make_request(ACT_COND, 4'd0, MODE_USR, '0, 32'h0000_0000));
        directed.push_back(make_request(ACT_COND, 4'd0, MODE_USR, '0, 32'hfa00_0000));
        directed.push_back(make_request(ACT_COND, 4'd0, MODE_USR, '0, 32'hf000_0000));
        directed.push_back(make_request(ACT_HALT, 4'd0, MODE_USR, 32'hffff_ffff, '0));
        directed.push_back(make_request(ACT_IRQ, 4'd0, MODE_USR, '0, '0));
        directed.push_back(make_request(ACT_UND, 4'd0, MODE_USR, '0, '0));
        directed.push_back(make_request(ACT_SPARE_LO, 4'd0, MODE_USR, 32'hffff_ffff, '1));
        directed.push_back(make_request(ACT_SPARE_HI, 4'd15, MODE_SYS, '1, '1));
        directed.push_back(make_request(ACT_RD_MODE, REG_LR, MODE_SYS, '0, '0));
        directed.push_back(make_request(ACT_RD_SPSR, 4'd0, MODE_IRQ, '0, '0));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int p = 0; p < PHASES; p++)
        begin
            write_config(phase_base[p], phase_v5[p]);
            if (p == 0)
            begin
                foreach (directed[i])
                    send_request(directed[i]);
            end
            for (int n = 0; n < phase_items[p]; n++)
            begin
                calm = (p == 1 && n >= 100 && n < 300);
                send_request(random_request());
            end
            calm = 1'b0;
            s_axis_tvalid <= 1'b0;
            while (pending_count != 0)
                @(negedge clk);
            repeat (2) @(negedge clk);
        end

        repeat (4) @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/brf_pkg.sv
hw/rtl/brf_cond.sv
hw/rtl/brf_core.sv
hw/rtl/banked_register_file_mode_control.sv
tb/sv/brf_checker.sv
tb/sv/banked_register_file_mode_control_tb.sv
